### src/bsr_pkg.sv
// Shared constants, element tables, pipeline types and the power-table builder
// for the MMFF94 empirical bond-stretch rule core. Depends on nothing.
`default_nettype none
package bsr_pkg;

   localparam int DEF_ELEMENT_TABLE_SIZE = 128;
   localparam int DEF_FRACTION_BITS      = 16;

   localparam int Z_W      = 7;
   localparam int DESIG_W  = 2;
   localparam int ORDER_W  = 2;
   localparam int K_W      = 24;
   localparam int LEN_W    = 18;
   localparam int STIFF_W  = 32;
   localparam int RADIUS_W = 16;
   localparam int ENEG_W   = 9;
   localparam int DIFF_W   = 9;
   localparam int CORR_W   = 11;
   localparam int CM10_W   = 10;

   localparam int ROM_ENTRIES = 54;
   localparam int ROM_IDX_W   = 6;
   localparam int POW_ENTRIES = 512;

   localparam int POW6_W = 108;
   localparam int NUM_W  = 134;
   localparam int DEN_W  = 109;
   localparam int REM_W  = 142;

   localparam logic [ROM_IDX_W-1:0] CARBON_IDX = 6'd6;
   localparam logic [Z_W-1:0]       HYDROGEN_Z = 7'd1;
   localparam logic [LEN_W-1:0]     LEN_MAX    = 18'h3FFFF;
   localparam logic [STIFF_W-1:0]   STIFF_MAX  = 32'hFFFF_FFFF;

   localparam logic [DESIG_W-1:0] DESIG_NONE  = 2'd0;
   localparam logic [DESIG_W-1:0] DESIG_ONE   = 2'd1;
   localparam logic [DESIG_W-1:0] DESIG_TWO   = 2'd2;
   localparam logic [DESIG_W-1:0] DESIG_THREE = 2'd3;

   typedef enum logic [2:0] {
      ORD_NONE, ORD_SINGLE, ORD_DOUBLE, ORD_TRIPLE, ORD_AROM, ORD_AROM_PI
   } order_type;

   // radius shrink per atom, ten-thousandths of an angstrom
   localparam logic [CORR_W-1:0] CORR_SINGLE_CONJ   = 11'd300;
   localparam logic [CORR_W-1:0] CORR_SINGLE_TRIPLE = 11'd800;
   localparam logic [CORR_W-1:0] CORR_DOUBLE        = 11'd1000;
   localparam logic [CORR_W-1:0] CORR_TRIPLE        = 11'd1700;
   localparam logic [CORR_W-1:0] CORR_AROM          = 11'd750;
   localparam logic [CORR_W-1:0] CORR_AROM_PI       = 11'd400;

   localparam logic [CM10_W-1:0] CM10_HYDROGEN = 10'd500;
   localparam logic [CM10_W-1:0] CM10_OTHER    = 10'd850;

   localparam logic [RADIUS_W-1:0] RADIUS_ROM [ROM_ENTRIES] = '{
      16'd7700, 16'd3300, 16'd7700, 16'd13400, 16'd9000, 16'd8100, 16'd7700, 16'd7287,
      16'd7200, 16'd7385, 16'd7700, 16'd15400, 16'd13000, 16'd12200, 16'd11500,
      16'd10910, 16'd10300, 16'd10100, 16'd7700, 16'd19600, 16'd17400, 16'd14400,
      16'd13600, 16'd7700, 16'd7700, 16'd7700, 16'd7700, 16'd7700, 16'd7700,
      16'd13800, 16'd13100, 16'd11900, 16'd12000, 16'd12000, 16'd11600, 16'd11500,
      16'd7700, 16'd21100, 16'd19200, 16'd16200, 16'd14800, 16'd7700, 16'd7700,
      16'd7700, 16'd7700, 16'd7700, 16'd7700, 16'd15300, 16'd14800, 16'd14600,
      16'd14000, 16'd14100, 16'd13500, 16'd13300
   };

   localparam logic [ENEG_W-1:0] ENEG_ROM [ROM_ENTRIES] = '{
      9'd250, 9'd220, 9'd250, 9'd97, 9'd147, 9'd201, 9'd250, 9'd307, 9'd350, 9'd410,
      9'd250, 9'd101, 9'd123, 9'd147, 9'd174, 9'd206, 9'd244, 9'd283, 9'd250, 9'd91,
      9'd104, 9'd130, 9'd150, 9'd160, 9'd160, 9'd150, 9'd180, 9'd180, 9'd180, 9'd190,
      9'd160, 9'd182, 9'd202, 9'd220, 9'd248, 9'd274, 9'd250, 9'd89, 9'd99, 9'd130,
      9'd140, 9'd160, 9'd180, 9'd190, 9'd220, 9'd220, 9'd220, 9'd190, 9'd170, 9'd149,
      9'd172, 9'd182, 9'd201, 9'd221
   };

   // stiff_max forces the stiffness to its maximum; sat is the reported flag
   typedef struct packed {
      logic [LEN_W-1:0] r0;
      logic             sat;
      logic             stiff_max;
   } side_type;

   typedef logic [31:0] pow_table_type [POW_ENTRIES];

   // floor((d/100)^1.4 * 2^f) by exact search: y^5 * 10^14 <= d^7 * 2^(5f)
   function automatic pow_table_type build_pow_table(int f);
      pow_table_type tab;
      logic [255:0]  rhs;
      logic [255:0]  lhs;
      logic [255:0]  cand;
      logic [255:0]  y;
      for (int d = 0; d < POW_ENTRIES; d++) begin
         rhs = 256'd1;
         for (int i = 0; i < 7; i++) rhs = rhs * 256'(d);
         rhs = rhs << (5 * f);
         y = '0;
         for (int b = f + 3; b >= 0; b--) begin
            cand = y | (256'd1 << b);
            lhs = 256'd1;
            for (int i = 0; i < 5; i++) lhs = lhs * cand;
            lhs = lhs * 256'd100000000000000;
            if (lhs <= rhs) y = cand;
         end
         tab[d] = y[31:0];
      end
      return tab;
   endfunction

endpackage
`default_nettype wire

### src/bsr_pow6.sv
// Four-stage pipelined sixth power of an 18-bit unsigned value.
// Depends on bsr_pkg for widths.
`default_nettype none
module bsr_pow6 (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [bsr_pkg::LEN_W-1:0]  x,
   output logic      [bsr_pkg::POW6_W-1:0] x6
);
   import bsr_pkg::*;

   localparam int CUBE_W = 3 * LEN_W;
   localparam int HALF_W = CUBE_W / 2;

   logic [LEN_W-1:0]    x_ff;
   logic [2*LEN_W-1:0]  x2_ff;
   logic [CUBE_W-1:0]   x3_ff;
   logic [2*HALF_W-1:0] hh_ff;
   logic [2*HALF_W-1:0] hl_ff;
   logic [2*HALF_W-1:0] ll_ff;
   logic [POW6_W-1:0]   x6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= x;
         x2_ff <= x * x;
         x3_ff <= CUBE_W'(x2_ff) * CUBE_W'(x_ff);
         // split the cube so each product stays near 27x27
         hh_ff <= x3_ff[CUBE_W-1:HALF_W] * x3_ff[CUBE_W-1:HALF_W];
         hl_ff <= x3_ff[CUBE_W-1:HALF_W] * x3_ff[HALF_W-1:0];
         ll_ff <= x3_ff[HALF_W-1:0] * x3_ff[HALF_W-1:0];
         x6_ff <= (POW6_W'(hh_ff) << (2 * HALF_W)) + (POW6_W'(hl_ff) << (HALF_W + 1))
                  + POW6_W'(ll_ff);
      end
   end

   assign x6 = x6_ff;

endmodule
`default_nettype wire

### src/bsr_divider.sv
// Fully pipelined restoring divider, one quotient bit per stage, 32 stages.
// Depends on bsr_pkg for widths and the side_type tag.
`default_nettype none
module bsr_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic                        in_valid,
   input  wire logic [bsr_pkg::NUM_W-1:0]   num,
   input  wire logic [bsr_pkg::DEN_W-1:0]   den,
   input  wire bsr_pkg::side_type           side,
   output logic                             out_valid,
   output logic      [bsr_pkg::STIFF_W-1:0] quo,
   output bsr_pkg::side_type                out_side
);
   import bsr_pkg::*;

   logic [REM_W-1:0]   rem_src  [STIFF_W+1];
   logic [DEN_W-1:0]   den_src  [STIFF_W+1];
   logic [STIFF_W-1:0] quo_src  [STIFF_W+1];
   side_type           side_src [STIFF_W+1];
   logic               vld_src  [STIFF_W+1];

   assign rem_src[0]  = REM_W'(num);
   assign den_src[0]  = den;
   assign quo_src[0]  = '0;
   assign side_src[0] = side;
   assign vld_src[0]  = in_valid;

   for (genvar j = 0; j < STIFF_W; j++) begin : g_stage
      localparam int BIT = STIFF_W - 1 - j;
      logic [REM_W-1:0]   sub_w;
      logic               take_w;
      logic [REM_W-1:0]   rem_ff;
      logic [DEN_W-1:0]   den_ff;
      logic [STIFF_W-1:0] quo_ff;
      side_type           side_ff;
      logic               vld_ff;

      always_comb begin
         sub_w  = REM_W'(den_src[j]) << BIT;
         take_w = rem_src[j] >= sub_w;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= take_w ? rem_src[j] - sub_w : rem_src[j];
            den_ff  <= den_src[j];
            quo_ff  <= take_w ? (quo_src[j] | (STIFF_W'(1) << BIT)) : quo_src[j];
            side_ff <= side_src[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_src[j];
         end
      end

      assign rem_src[j+1]  = rem_ff;
      assign den_src[j+1]  = den_ff;
      assign quo_src[j+1]  = quo_ff;
      assign side_src[j+1] = side_ff;
      assign vld_src[j+1]  = vld_ff;
   end

   assign out_valid = vld_src[STIFF_W];
   assign quo       = quo_src[STIFF_W];
   assign out_side  = side_src[STIFF_W];

endmodule
`default_nettype wire

### src/bond_stretch_empirical_rule_core.sv
// Top level of the MMFF94 empirical bond-stretch rule pipeline.
// Depends on bsr_pkg, bsr_pow6 and bsr_divider.
//
//   channel  dir  handshake            payload
//   req_     in   req_valid/req_stall  atoms, designators, order, flags, k, length
//   rsp_     out  rsp_valid/rsp_stall  bond length, stiffness, saturated
//
// One request per cycle while no response is stalled; 8 stages for r0, 4 for the
// sixth powers, 4 for the stiffness operands, 32 divider stages and the output.
// The divider sets the depth: it retires one quotient bit per stage.
// Reset clears only the valid bits. A stalled response freezes the whole
// pipeline, and req_stall follows it in the same cycle.
`default_nettype none
module bond_stretch_empirical_rule_core #(
   parameter int ELEMENT_TABLE_SIZE = bsr_pkg::DEF_ELEMENT_TABLE_SIZE,
   parameter int FRACTION_BITS      = bsr_pkg::DEF_FRACTION_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [bsr_pkg::Z_W-1:0]       req_atomic_number_a,
   input  wire logic [bsr_pkg::Z_W-1:0]       req_atomic_number_b,
   input  wire logic [bsr_pkg::DESIG_W-1:0]   req_multibond_desig_a,
   input  wire logic [bsr_pkg::DESIG_W-1:0]   req_multibond_desig_b,
   input  wire logic [bsr_pkg::ORDER_W-1:0]   req_bond_order,
   input  wire logic                          req_in_aromatic_ring,
   input  wire logic                          req_pi_lone_pair_a,
   input  wire logic                          req_pi_lone_pair_b,
   input  wire logic [bsr_pkg::K_W-1:0]       req_rule_stiffness,
   input  wire logic [bsr_pkg::LEN_W-1:0]     req_rule_length,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [bsr_pkg::LEN_W-1:0]     rsp_bond_length_out,
   output logic      [bsr_pkg::STIFF_W-1:0]   rsp_stiffness_out,
   output logic                               rsp_saturated
);
   import bsr_pkg::*;

   localparam int F      = FRACTION_BITS;
   localparam int PW     = F + 4;
   localparam int NW     = RADIUS_W + F;
   localparam int NEGW   = PW + CM10_W;
   localparam int YW     = NW - 4;
   localparam int MW     = YW - 9;
   localparam int HIW    = YW - 16;
   localparam int PRODW  = YW + MW;
   localparam int STAGES = 16;
   localparam int DLY    = 4;
   localparam int CHUNK  = 27;
   localparam int NCHUNK = POW6_W / CHUNK;
   localparam int AW     = NUM_W - 2;
   localparam logic [MW-1:0] RECIP = MW'((64'd1 << YW) / 64'd625);
   localparam pow_table_type POW_TABLE = build_pow_table(F);

   logic adv;
   logic v_ff [STAGES];

   // stage 1
   logic [ROM_IDX_W-1:0] ia_w, ib_w;
   order_type            order_w;
   logic [CORR_W-1:0]    corr_w;
   logic [ENEG_W-1:0]    ea_w, eb_w;
   logic [RADIUS_W-1:0] s1_sum_ff;
   logic [DIFF_W-1:0]   s1_d_ff;
   logic                s1_hyd_ff;
   logic [K_W-1:0]      k_ff   [8];
   logic [LEN_W-1:0]    len_ff [8];
   // stages 2..8
   logic [PW-1:0]       s2_p_ff;
   logic [NW-1:0]       s2_pos_ff, s3_pos_ff;
   logic                s2_hyd_ff;
   logic [NEGW-1:0]     s3_neg_ff;
   logic [NW:0]         s4_diff_w;
   logic [NW-1:0]       s4_x_ff;
   logic                s4_neg_ff, s5_neg_ff, s6_neg_ff, s7_neg_ff;
   logic [YW-1:0]       s5_y_ff, s6_y_ff;
   logic [16+MW-1:0]    s5_lo_ff;
   logic [HIW+MW-1:0]   s5_hi_ff;
   logic [PRODW-1:0]    s6_prod_w;
   logic [MW-1:0]       s6_q0_ff;
   logic [YW-1:0]       s7_rem_w;
   logic [MW-1:0]       s7_q_ff;
   logic                s8_over_w;
   side_type            s8_side_ff;
   // stages 9..16
   logic [POW6_W-1:0]   r6_w, l6_w;
   side_type            side_dly_ff [DLY];
   logic [K_W-1:0]      k_dly_ff    [DLY];
   logic [CHUNK+K_W-1:0] s13_pp_ff [NCHUNK];
   logic [POW6_W-1:0]   s13_r6_ff, s14_r6_ff;
   side_type            s13_side_ff, s14_side_ff, s15_side_ff;
   logic [AW-1:0]       s14_a_w;
   logic [AW-1:0]       s14_a_ff;
   logic [NUM_W-1:0]    s15_a_ff, s16_a_ff;
   logic [DEN_W-1:0]    s15_b_ff, s16_b_ff;
   logic                s16_ovf_w;
   side_type            s16_side_ff;
   // divider and output
   logic                div_valid_w;
   logic [STIFF_W-1:0]  div_quo_w;
   side_type            div_side_w;
   logic                rsp_valid_ff;
   logic [LEN_W-1:0]    rsp_len_ff;
   logic [STIFF_W-1:0]  rsp_stiff_ff;
   logic                rsp_sat_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_comb begin
      ia_w = (int'(req_atomic_number_a) >= ELEMENT_TABLE_SIZE ||
              int'(req_atomic_number_a) >= ROM_ENTRIES) ? CARBON_IDX
             : ROM_IDX_W'(req_atomic_number_a);
      ib_w = (int'(req_atomic_number_b) >= ELEMENT_TABLE_SIZE ||
              int'(req_atomic_number_b) >= ROM_ENTRIES) ? CARBON_IDX
             : ROM_IDX_W'(req_atomic_number_b);
      priority if (req_multibond_desig_a == DESIG_ONE && req_multibond_desig_b == DESIG_ONE)
         order_w = ORD_AROM;
      else if ((req_multibond_desig_a == DESIG_ONE && req_multibond_desig_b == DESIG_TWO) ||
               (req_multibond_desig_a == DESIG_TWO && req_multibond_desig_b == DESIG_ONE))
         order_w = ORD_AROM_PI;
      else if (req_in_aromatic_ring)
         order_w = (req_pi_lone_pair_a || req_pi_lone_pair_b) ? ORD_AROM_PI : ORD_AROM;
      else
         order_w = order_type'({1'b0, req_bond_order});
      unique case (order_w)
         ORD_NONE:    corr_w = '0;
         ORD_SINGLE: begin
            if ((req_multibond_desig_a == DESIG_ONE || req_multibond_desig_a == DESIG_TWO) &&
                (req_multibond_desig_b == DESIG_ONE || req_multibond_desig_b == DESIG_TWO))
               corr_w = CORR_SINGLE_CONJ;
            else if (req_multibond_desig_a == DESIG_THREE &&
                     req_multibond_desig_b == DESIG_THREE)
               corr_w = CORR_SINGLE_TRIPLE;
            else
               corr_w = '0;
         end
         ORD_DOUBLE:  corr_w = CORR_DOUBLE;
         ORD_TRIPLE:  corr_w = CORR_TRIPLE;
         ORD_AROM:    corr_w = CORR_AROM;
         ORD_AROM_PI: corr_w = CORR_AROM_PI;
         default:     corr_w = '0;
      endcase
      ea_w = ENEG_ROM[ia_w];
      eb_w = ENEG_ROM[ib_w];
   end

   always_comb begin
      s4_diff_w = (NW+1)'(s3_pos_ff) - (NW+1)'(s3_neg_ff) + (NW+1)'(5000);
      s6_prod_w = (PRODW'(s5_hi_ff) << 16) + PRODW'(s5_lo_ff);
      s7_rem_w  = s6_y_ff - YW'(YW'(s6_q0_ff) * YW'(625));
      s8_over_w = 32'(s7_q_ff) > 32'(LEN_MAX);
      s16_ovf_w = REM_W'(s15_a_ff) >= (REM_W'(s15_b_ff) << STIFF_W);
      s14_a_w   = '0;
      for (int i = 0; i < NCHUNK; i++)
         s14_a_w = s14_a_w + (AW'(s13_pp_ff[i]) << (CHUNK * i));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // radii sum, electronegativity gap
         s1_sum_ff <= RADIUS_W'(17'(RADIUS_ROM[ia_w]) + 17'(RADIUS_ROM[ib_w])
                                - 17'({corr_w, 1'b0}));
         s1_d_ff   <= (ea_w > eb_w) ? ea_w - eb_w : eb_w - ea_w;
         s1_hyd_ff <= req_atomic_number_a == HYDROGEN_Z ||
                      req_atomic_number_b == HYDROGEN_Z;
         k_ff[0]   <= req_rule_stiffness;
         len_ff[0] <= req_rule_length;
         for (int i = 1; i < 8; i++) begin
            k_ff[i]   <= k_ff[i-1];
            len_ff[i] <= len_ff[i-1];
         end
         s2_p_ff   <= PW'(POW_TABLE[s1_d_ff]);
         s2_pos_ff <= {s1_sum_ff, F'(0)};
         s2_hyd_ff <= s1_hyd_ff;
         s3_neg_ff <= NEGW'(s2_p_ff) * NEGW'(s2_hyd_ff ? CM10_HYDROGEN : CM10_OTHER);
         s3_pos_ff <= s2_pos_ff;
         s4_neg_ff <= (NW+1)'(s3_neg_ff) > (NW+1)'(s3_pos_ff);
         s4_x_ff   <= s4_diff_w[NW-1:0];
         // divide by 10000 as a shift by 4 and a reciprocal of 625
         s5_y_ff   <= s4_x_ff[NW-1:4];
         s5_lo_ff  <= s4_x_ff[19:4] * RECIP;
         s5_hi_ff  <= s4_x_ff[NW-1:20] * RECIP;
         s5_neg_ff <= s4_neg_ff;
         s6_q0_ff  <= s6_prod_w[PRODW-1:YW];
         s6_y_ff   <= s5_y_ff;
         s6_neg_ff <= s5_neg_ff;
         s7_q_ff   <= s6_q0_ff + MW'(s7_rem_w >= YW'(625));
         s7_neg_ff <= s6_neg_ff;
         if (s7_neg_ff) begin
            s8_side_ff.r0 <= '0;
         end else if (s8_over_w) begin
            s8_side_ff.r0 <= LEN_MAX;
         end else begin
            s8_side_ff.r0 <= LEN_W'(s7_q_ff);
         end
         s8_side_ff.sat <= s7_neg_ff || s8_over_w || (!s7_neg_ff && s7_q_ff == '0);
         // a clamped long length still gets a real stiffness; here only zero length forces max
         s8_side_ff.stiff_max <= s7_neg_ff || s7_q_ff == '0;
         // hold side info while the sixth powers form
         side_dly_ff[0] <= s8_side_ff;
         k_dly_ff[0]    <= k_ff[7];
         for (int i = 1; i < DLY; i++) begin
            side_dly_ff[i] <= side_dly_ff[i-1];
            k_dly_ff[i]    <= k_dly_ff[i-1];
         end
         for (int i = 0; i < NCHUNK; i++)
            s13_pp_ff[i] <= (CHUNK+K_W)'(l6_w[CHUNK*i +: CHUNK]) * (CHUNK+K_W)'(k_dly_ff[DLY-1]);
         s13_r6_ff   <= r6_w;
         s13_side_ff <= side_dly_ff[DLY-1];
         s14_a_ff    <= s14_a_w;
         s14_r6_ff   <= s13_r6_ff;
         s14_side_ff <= s13_side_ff;
         // round half up: (2*k*len^6 + r0^6) / (2*r0^6)
         s15_a_ff    <= {s14_a_ff, 1'b0} + NUM_W'(s14_r6_ff);
         s15_b_ff    <= {s14_r6_ff, 1'b0};
         s15_side_ff <= s14_side_ff;
         s16_a_ff    <= s15_a_ff;
         s16_b_ff    <= s15_b_ff;
         s16_side_ff.r0        <= s15_side_ff.r0;
         s16_side_ff.sat       <= s15_side_ff.sat || s16_ovf_w;
         s16_side_ff.stiff_max <= s15_side_ff.stiff_max || s16_ovf_w;
         rsp_len_ff   <= div_side_w.r0;
         rsp_stiff_ff <= div_side_w.stiff_max ? STIFF_MAX : div_quo_w;
         rsp_sat_ff   <= div_side_w.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) v_ff[i] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i < STAGES; i++) v_ff[i] <= v_ff[i-1];
         rsp_valid_ff <= div_valid_w;
      end
   end

   bsr_pow6 u_r0_pow (
      .clock (clock),
      .en    (adv),
      .x     (s8_side_ff.r0),
      .x6    (r6_w)
   );

   bsr_pow6 u_len_pow (
      .clock (clock),
      .en    (adv),
      .x     (len_ff[7]),
      .x6    (l6_w)
   );

   bsr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v_ff[STAGES-1]),
      .num       (s16_a_ff),
      .den       (s16_b_ff),
      .side      (s16_side_ff),
      .out_valid (div_valid_w),
      .quo       (div_quo_w),
      .out_side  (div_side_w)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_bond_length_out = rsp_len_ff;
   assign rsp_stiffness_out   = rsp_stiff_ff;
   assign rsp_saturated       = rsp_sat_ff;

`ifndef NO_ASSERTIONS
   a_zero_len_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bond_length_out == '0 |-> rsp_saturated)
      else $error("zero bond length without saturation flag");

   a_reset_drains: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid right after reset");

   a_stall_holds_entry: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> v_ff[0] == $past(v_ff[0]))
      else $error("first stage moved while stalled");
`endif

endmodule
`default_nettype wire

### tb/bond_stretch_empirical_rule_core_tb.sv
// Self-checking testbench for bond_stretch_empirical_rule_core: directed bonds, random
// bonds and a long response stall, checked against an in-bench bond-rule predictor.
// Depends on bsr_pkg and the core RTL.
`default_nettype none
module bond_stretch_empirical_rule_core_tb;
   import bsr_pkg::*;

   typedef struct packed {
      logic [Z_W-1:0]     za;
      logic [Z_W-1:0]     zb;
      logic [DESIG_W-1:0] da;
      logic [DESIG_W-1:0] db;
      logic [ORDER_W-1:0] order;
      logic               arom;
      logic               pa;
      logic               pb;
      logic [K_W-1:0]     k;
      logic [LEN_W-1:0]   len;
   } bond_type;

   typedef struct packed {
      logic [LEN_W-1:0]   r0;
      logic [STIFF_W-1:0] stiff;
      logic               sat;
   } rule_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   bond_type req_bond = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [LEN_W-1:0] rsp_bond_length_out;
   logic [STIFF_W-1:0] rsp_stiffness_out;
   logic rsp_saturated;

   rule_result_type pending_results[$];
   int mismatches = 0;
   bit hold_off_request = 1'b0;
   bit hold_off_done = 1'b0;

   bond_stretch_empirical_rule_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_atomic_number_a(req_bond.za), .req_atomic_number_b(req_bond.zb),
      .req_multibond_desig_a(req_bond.da), .req_multibond_desig_b(req_bond.db),
      .req_bond_order(req_bond.order), .req_in_aromatic_ring(req_bond.arom),
      .req_pi_lone_pair_a(req_bond.pa), .req_pi_lone_pair_b(req_bond.pb),
      .req_rule_stiffness(req_bond.k), .req_rule_length(req_bond.len),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_bond_length_out(rsp_bond_length_out),
      .rsp_stiffness_out(rsp_stiffness_out), .rsp_saturated(rsp_saturated)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

   // floor((d/100)^1.4 * 2^F): largest y with y^5 * 10^14 <= d^7 * 2^(5F)
   function automatic logic [31:0] eneg_power(input int unsigned d);
      logic [255:0] bound;
      logic [255:0] trial;
      logic [255:0] y5;
      logic [31:0] y;
      y = '0;
      bound = 256'(d) * d * d * d * d * d * d;
      bound = bound << (5 * DEF_FRACTION_BITS);
      for (int b = DEF_FRACTION_BITS + 3; b >= 0; b--) begin
         trial = 256'(y | (32'd1 << b));
         y5 = trial * trial * trial * trial * trial;
         if (y5 * 256'd100000000000000 <= bound) y = trial[31:0];
      end
      return y;
   endfunction

   function automatic int unsigned element_slot(input logic [Z_W-1:0] z);
      if (z >= DEF_ELEMENT_TABLE_SIZE || z >= ROM_ENTRIES) return CARBON_IDX;
      return z;
   endfunction

   function automatic rule_result_type predict_bond(input bond_type bd);
      rule_result_type res;
      order_type eff;
      int unsigned ia, ib, d;
      longint shrink, radius_sum, num, q, cm10;
      logic [255:0] r6, top, den;
      res = '0;
      shrink = 0;
      ia = element_slot(bd.za);
      ib = element_slot(bd.zb);
      if (bd.da == DESIG_ONE && bd.db == DESIG_ONE) eff = ORD_AROM;
      else if ((bd.da == DESIG_ONE && bd.db == DESIG_TWO) ||
               (bd.da == DESIG_TWO && bd.db == DESIG_ONE)) eff = ORD_AROM_PI;
      else if (bd.arom) eff = (bd.pa || bd.pb) ? ORD_AROM_PI : ORD_AROM;
      else eff = order_type'({1'b0, bd.order});
      case (eff)
         ORD_SINGLE: begin
            if ((bd.da == DESIG_ONE || bd.da == DESIG_TWO) &&
                (bd.db == DESIG_ONE || bd.db == DESIG_TWO)) shrink = CORR_SINGLE_CONJ;
            else if (bd.da == DESIG_THREE && bd.db == DESIG_THREE)
               shrink = CORR_SINGLE_TRIPLE;
         end
         ORD_DOUBLE:  shrink = CORR_DOUBLE;
         ORD_TRIPLE:  shrink = CORR_TRIPLE;
         ORD_AROM:    shrink = CORR_AROM;
         ORD_AROM_PI: shrink = CORR_AROM_PI;
         default:     shrink = 0;
      endcase
      radius_sum = longint'(RADIUS_ROM[ia]) + longint'(RADIUS_ROM[ib]) - 2 * shrink;
      d = ENEG_ROM[ia] > ENEG_ROM[ib] ? ENEG_ROM[ia] - ENEG_ROM[ib]
                                      : ENEG_ROM[ib] - ENEG_ROM[ia];
      cm10 = (bd.za == HYDROGEN_Z || bd.zb == HYDROGEN_Z) ? CM10_HYDROGEN : CM10_OTHER;
      num = radius_sum * (longint'(1) << DEF_FRACTION_BITS) - cm10 * longint'(eneg_power(d));
      if (num < 0) begin
         res.r0 = '0;
         res.sat = 1'b1;
      end else begin
         q = (num + 5000) / 10000;
         if (q > longint'(LEN_MAX)) begin
            res.r0 = LEN_MAX;
            res.sat = 1'b1;
         end else begin
            res.r0 = q[LEN_W-1:0];
         end
      end
      if (res.r0 == 0) begin
         res.stiff = STIFF_MAX;
         res.sat = 1'b1;
      end else begin
         r6 = 256'(res.r0);
         r6 = r6 * r6 * r6 * r6 * r6 * r6;
         top = 256'(bd.len);
         top = top * top * top * top * top * top * 256'(bd.k) * 2 + r6;
         den = r6 * 2;
         if ((den << 32) <= top) begin
            res.stiff = STIFF_MAX;
            res.sat = 1'b1;
         end else begin
            top = top / den;
            res.stiff = top[31:0];
         end
      end
      return res;
   endfunction

   function automatic int unsigned random_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   task automatic send_bond(input bond_type bd, input int unsigned gap);
      @(negedge clock);
      req_bond <= bd;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_bond(bd));
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // checker: compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      rule_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response r0=%0d", rsp_bond_length_out);
         end else begin
            want = pending_results.pop_front();
            if (want.r0 !== rsp_bond_length_out || want.stiff !== rsp_stiffness_out ||
                want.sat !== rsp_saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch r0 %0d/%0d stiff %0d/%0d sat %0b/%0b",
                           want.r0, rsp_bond_length_out, want.stiff, rsp_stiffness_out,
                           want.sat, rsp_saturated);
            end
         end
      end
   end

   // receiver: random stall, plus one long hold-off on request
   initial begin
      int unsigned run;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_off_done) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            hold_off_done = 1'b1;
            rsp_stall <= 1'b0;
         end else begin
            run = random_gap();
            if (run > 0) begin
               rsp_stall <= 1'b1;
               repeat (run - 1) @(negedge clock);
               @(negedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(6)) @(negedge clock);
         end
      end
   end

   function automatic bond_type random_bond();
      bond_type bd;
      logic [Z_W-1:0] common_z [12] = '{1, 6, 7, 8, 9, 14, 15, 16, 17, 35, 53, 37};
      bd = '0;
      if ($urandom_range(9) < 7) begin
         bd.za = common_z[$urandom_range(11)];
         bd.zb = common_z[$urandom_range(11)];
         bd.len = LEN_W'($urandom_range(131072, 62000));
         bd.k = K_W'($urandom_range(24'h3FFFFF));
      end else begin
         bd.za = Z_W'($urandom_range(127));
         bd.zb = Z_W'($urandom_range(127));
         bd.len = LEN_W'($urandom_range(LEN_MAX));
         bd.k = K_W'($urandom_range(24'hFFFFFF));
      end
      bd.da = DESIG_W'($urandom_range(3));
      bd.db = DESIG_W'($urandom_range(3));
      bd.order = ORDER_W'($urandom_range(3));
      bd.arom = 1'($urandom_range(1));
      bd.pa = 1'($urandom_range(1));
      bd.pb = 1'($urandom_range(1));
      return bd;
   endfunction

   function automatic bond_type make_bond(input int za, zb, da, db, ord, ar, pa, pb,
                                          input int unsigned k, len);
      bond_type bd;
      bd.za = Z_W'(za); bd.zb = Z_W'(zb); bd.da = DESIG_W'(da); bd.db = DESIG_W'(db);
      bd.order = ORDER_W'(ord);
      bd.arom = 1'(ar); bd.pa = 1'(pa); bd.pb = 1'(pb);
      bd.k = K_W'(k); bd.len = LEN_W'(len);
      return bd;
   endfunction

   task automatic test_directed();
      send_bond(make_bond(0, 127, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      send_bond(make_bond(127, 0, 3, 3, 3, 1, 1, 1, 24'hFFFFFF, LEN_MAX), 0);
      send_bond(make_bond(1, 1, 0, 0, 1, 0, 0, 0, 300000, 70000), 0);
      send_bond(make_bond(6, 6, DESIG_ONE, DESIG_ONE, 1, 0, 0, 0, 400000, 95000), 1);
      send_bond(make_bond(6, 7, DESIG_ONE, DESIG_TWO, 2, 0, 0, 0, 400000, 90000), 0);
      send_bond(make_bond(7, 6, DESIG_TWO, DESIG_ONE, 0, 0, 0, 0, 400000, 90000), 0);
      send_bond(make_bond(6, 6, DESIG_TWO, DESIG_TWO, 1, 0, 0, 0, 350000, 96000), 2);
      send_bond(make_bond(6, 6, DESIG_THREE, DESIG_THREE, 1, 0, 0, 0, 350000, 90000), 0);
      send_bond(make_bond(6, 8, 0, 0, 1, 0, 0, 0, 350000, 94000), 0);
      send_bond(make_bond(6, 8, 0, 0, 2, 0, 0, 0, 600000, 80000), 0);
      send_bond(make_bond(6, 7, 0, 0, 3, 0, 0, 0, 900000, 75000), 0);
      send_bond(make_bond(6, 6, 0, 0, 1, 1, 0, 0, 500000, 91000), 0);
      send_bond(make_bond(6, 7, 0, 0, 1, 1, 1, 0, 500000, 89000), 0);
      send_bond(make_bond(7, 6, 0, 0, 1, 1, 0, 1, 500000, 89000), 0);
      send_bond(make_bond(37, 37, 0, 0, 0, 0, 0, 0, 100000, 200000), 0);
      send_bond(make_bond(9, 37, 0, 0, 3, 0, 0, 0, 24'hFFFFFF, LEN_MAX), 0);
      send_bond(make_bond(1, 53, 0, 0, 1, 0, 0, 0, 1, 1), 0);
      send_bond(make_bond(53, 54, 0, 0, 1, 0, 0, 0, 300000, 140000), 0);
      send_bond(make_bond(55, 1, 0, 0, 1, 0, 0, 0, 300000, 70000), 0);
   endtask

   task automatic test_random(input int unsigned count);
      repeat (count) send_bond(random_bond(), random_gap());
   endtask

   task automatic test_backpressure();
      hold_off_request = 1'b1;
      repeat (120) send_bond(random_bond(), 0);
      while (!hold_off_done) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(800);
      test_backpressure();
      test_random(860);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

### filelist.f
src/bsr_pkg.sv
src/bsr_pow6.sv
src/bsr_divider.sv
src/bond_stretch_empirical_rule_core.sv
tb/bond_stretch_empirical_rule_core_tb.sv
